// ===== src/fcss_pkg.sv =====
// Shared types and constants for the common-source FET stage solver.
package fcss_pkg;

  localparam int MAX_ITERATIONS = 5;
  localparam int ITER_W         = $clog2(MAX_ITERATIONS + 1);

  localparam int GAIN_Q12       = 2867;
  localparam int ROUND_Q12      = 2048;
  localparam int VCC_Q12        = 20480;
  localparam int VGS_LIMIT_Q12  = 20480;
  localparam int VOLT_MIN_Q12   = -32768;
  localparam int DROP_LIMIT     = VCC_Q12 - VOLT_MIN_Q12;
  localparam int TOL_LSB        = 4;

  localparam int CFG_AW = 2;
  localparam int CFG_DW = 24;

  localparam logic [CFG_AW-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_AW-1:0] REG_KCOEFF    = 2'd1;
  localparam logic [CFG_AW-1:0] REG_LAMBDA    = 2'd2;
  localparam logic [CFG_AW-1:0] REG_RDRAIN    = 2'd3;

  localparam logic signed [15:0] THRESHOLD_RST = 16'sd8192;
  localparam logic [23:0]        KCOEFF_RST    = 24'd16777;
  localparam logic [15:0]        LAMBDA_RST    = 16'd1311;
  localparam logic [15:0]        RDRAIN_RST    = 16'd1000;

  typedef struct packed {
    logic signed [15:0] thr;
    logic [23:0]        k;
    logic [15:0]        lambda;
    logic [15:0]        rd;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic gate;
    logic od;
    logic mul1;
    logic mul2;
    logic mul3;
    logic cur;
    logic drop;
    logic update;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic conv;
    logic out_stall;
  } status_t;

endpackage

// ===== src/fet_common_source_stage_solver.sv =====
// Top level of the common-source FET stage solver: configuration registers and wiring.
//
// Usage:
//   Input channel in_*: one signed Q4.12 voltage per transfer on in_tdata.
//   Output channel out_*: one Q4.12 drain voltage (0..5 V) per input.
//   Configuration port cfg_*: write threshold, K, lambda and load resistance
//   by index while the block is idle; values apply to the next input.
//   Sequence: gate scaling and overdrive setup, then load-line passes through
//   the multiply, current, drop and update steps, up to 5 passes, then the
//   output register. One item is in flight at a time: a new input is taken
//   only in idle, once the sequential pass loop through the multipliers,
//   which every pass reuses, has finished and the result has been emitted.
//   The output register holds the last result while the receiver stalls;
//   a new input is still accepted and solved, and waits for that register
//   to drain before it is written.
//   Reset (rst_n low, synchronous) loads the default configuration, empties
//   the output register and returns the sequencer to idle.
module fet_common_source_stage_solver (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,   // [15:0] input_voltage
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [15:0]                   out_tdata,  // [14:0] output_voltage, [15] zero
  input  logic                          cfg_we,
  input  logic [fcss_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [fcss_pkg::CFG_DW-1:0]   cfg_wdata
);

  fcss_pkg::cfg_t    cfg_r;
  fcss_pkg::cmd_t    cmd;
  fcss_pkg::status_t status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thr    <= fcss_pkg::THRESHOLD_RST;
      cfg_r.k      <= fcss_pkg::KCOEFF_RST;
      cfg_r.lambda <= fcss_pkg::LAMBDA_RST;
      cfg_r.rd     <= fcss_pkg::RDRAIN_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        fcss_pkg::REG_THRESHOLD: cfg_r.thr    <= cfg_wdata[15:0];
        fcss_pkg::REG_KCOEFF:    cfg_r.k      <= cfg_wdata;
        fcss_pkg::REG_LAMBDA:    cfg_r.lambda <= cfg_wdata[15:0];
        fcss_pkg::REG_RDRAIN:    cfg_r.rd     <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  fcss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  fcss_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== src/fcss_ctrl.sv =====
// Sequencer for the gate, device-model and update steps of the drain solve.
module fcss_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  fcss_pkg::status_t  status,
  output fcss_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_GATE, ST_OD, ST_MUL1, ST_MUL2, ST_MUL3,
    ST_CUR, ST_DROP, ST_UPD, ST_FINISH
  } state_t;

  state_t                        state_r, state_nxt;
  logic [fcss_pkg::ITER_W-1:0]   iter_r, iter_nxt;
  logic                          last_iter;

  assign in_tready = (state_r == ST_IDLE);
  assign last_iter = (iter_r == fcss_pkg::ITER_W'(fcss_pkg::MAX_ITERATIONS - 1));

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    iter_nxt   = iter_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          iter_nxt  = '0;
          state_nxt = ST_GATE;
        end
      end
      ST_GATE: begin
        cmd.gate  = 1'b1;
        state_nxt = ST_OD;
      end
      ST_OD: begin
        cmd.od    = 1'b1;
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = ST_MUL3;
      end
      ST_MUL3: begin
        cmd.mul3  = 1'b1;
        state_nxt = ST_CUR;
      end
      ST_CUR: begin
        cmd.cur   = 1'b1;
        state_nxt = ST_DROP;
      end
      ST_DROP: begin
        cmd.drop  = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        if (status.conv || last_iter) begin
          state_nxt = ST_FINISH;
        end else begin
          iter_nxt  = iter_r + 1'b1;
          state_nxt = ST_MUL1;
        end
      end
      ST_FINISH: begin
        if (!status.out_stall) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
    end
  end

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    iter_r <= fcss_pkg::ITER_W'(fcss_pkg::MAX_ITERATIONS - 1))
    else $error("iteration count beyond limit");

  a_emit_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !status.out_stall)
    else $error("result emitted into a stalled output register");

  a_load_to_gate: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == ST_GATE))
    else $error("transfer not followed by gate step");

  a_update_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.update && status.conv) |=> (state_r == ST_FINISH))
    else $error("converged solve did not finish");

endmodule

// ===== src/fcss_datapath.sv =====
// Gate scaling, square-law drain current, load-line update and output register.
module fcss_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  fcss_pkg::cfg_t     cfg,
  input  fcss_pkg::cmd_t     cmd,
  output fcss_pkg::status_t  status,
  input  logic [15:0]        in_tdata,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [15:0]        out_tdata
);

  logic signed [15:0] vin_r;
  logic signed [15:0] vgs_r;
  logic signed [16:0] od_r;
  logic signed [15:0] vds_r;
  logic [31:0]        q_r;
  logic [31:0]        m_r;
  logic               on_r;
  logic               sat_r;
  logic [30:0]        p_r;
  logic [34:0]        pm_r;
  logic [35:0]        id_r;
  logic [39:0]        drop_r;
  logic               out_valid_r;
  logic [14:0]        out_data_r;

  logic signed [28:0] gprod;
  logic signed [16:0] vg;
  logic signed [15:0] vgs_c;
  logic [15:0]        vdsc;
  logic [15:0]        uod;
  logic               od_pos;
  logic               sat;
  logic [16:0]        tw;
  logic [32:0]        tri_prod;
  logic [55:0]        kq;
  logic [62:0]        pm_full;
  logic [51:0]        drop_full;
  logic signed [17:0] next_v;
  logic signed [17:0] diff;
  logic signed [15:0] next_s;
  logic [14:0]        vout;

  // gate: round(vin * 0.7), clamp to +-5 V
  always_comb begin
    gprod = $signed({{13{vin_r[15]}}, vin_r}) * $signed(29'(fcss_pkg::GAIN_Q12))
            + $signed(29'(fcss_pkg::ROUND_Q12));
    vg    = gprod[28:12];
    if (vg > fcss_pkg::VGS_LIMIT_Q12) begin
      vgs_c = 16'(fcss_pkg::VGS_LIMIT_Q12);
    end else if (vg < -fcss_pkg::VGS_LIMIT_Q12) begin
      vgs_c = 16'(-fcss_pkg::VGS_LIMIT_Q12);
    end else begin
      vgs_c = vg[15:0];
    end
  end

  // device model operands
  always_comb begin
    vdsc     = vds_r[15] ? 16'd0 : vds_r;
    uod      = od_r[15:0];
    od_pos   = !od_r[16] && (od_r != '0);
    sat      = (vdsc >= uod);
    tw       = {uod, 1'b0} - {1'b0, vdsc};
    tri_prod = 33'(vdsc) * 33'(tw);
    kq       = 56'(cfg.k) * 56'(q_r);
    pm_full  = 63'(p_r) * 63'(m_r);
    drop_full = 52'(id_r) * 52'(cfg.rd);
  end

  // load line and convergence
  always_comb begin
    if (drop_r > 40'(fcss_pkg::DROP_LIMIT)) begin
      next_v = 18'(fcss_pkg::VOLT_MIN_Q12);
    end else begin
      next_v = 18'(fcss_pkg::VCC_Q12) - $signed({2'b00, drop_r[15:0]});
    end
    next_s = next_v[15:0];
    diff   = next_v - 18'(vds_r);
    status.conv      = (diff >= -fcss_pkg::TOL_LSB) && (diff <= fcss_pkg::TOL_LSB);
    status.out_stall = out_valid_r && !out_tready;
  end

  always_comb begin
    if (vds_r[15]) begin
      vout = '0;
    end else if (vds_r > fcss_pkg::VCC_Q12) begin
      vout = 15'(fcss_pkg::VCC_Q12);
    end else begin
      vout = vds_r[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vin_r <= in_tdata;
      vds_r <= 16'(fcss_pkg::VCC_Q12);
    end
    if (cmd.gate) begin
      vgs_r <= vgs_c;
    end
    if (cmd.od) begin
      od_r <= 17'(vgs_r) - 17'(cfg.thr);
    end
    if (cmd.mul1) begin
      q_r   <= sat ? (32'(uod) * 32'(uod)) : tri_prod[31:0];
      m_r   <= 32'(cfg.lambda) * 32'(vdsc);
      on_r  <= od_pos;
      sat_r <= sat;
    end
    if (cmd.mul2) begin
      p_r <= kq[55:25];
    end
    if (cmd.mul3) begin
      pm_r <= pm_full[62:28];
    end
    if (cmd.cur) begin
      if (!on_r) begin
        id_r <= '0;
      end else if (sat_r) begin
        id_r <= 36'(p_r) + 36'(pm_r);
      end else begin
        id_r <= 36'(p_r);
      end
    end
    if (cmd.drop) begin
      drop_r <= drop_full[51:12];
    end
    if (cmd.update && !status.conv) begin
      vds_r <= next_s;
    end
    if (cmd.emit) begin
      out_data_r <= vout;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r};

endmodule
